// ===== rtl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and constants for the I2C master bit sequencer
// Command codes, register indexes, sequencer phases and the transaction
// payload structs of the command and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  // Command codes carried in the kind field
  localparam logic [2:0] KindTick  = 3'd0;
  localparam logic [2:0] KindStart = 3'd1;
  localparam logic [2:0] KindStop  = 3'd2;
  localparam logic [2:0] KindWrite = 3'd3;
  localparam logic [2:0] KindAck   = 3'd4;
  localparam logic [2:0] KindRead  = 3'd5;

  // Configuration register indexes and widths
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 8;
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgAckTimeout = 8'd1;

  // Register reset values
  localparam logic [7:0] HalfPeriodReset = 8'd3;
  localparam logic [7:0] AckTimeoutReset = 8'd250;

  // Bits in one byte
  localparam logic [3:0] BitsPerByte = 4'd8;

  // Sequencer phases
  typedef enum logic [3:0] {
    PhIdle   = 4'd0,
    PhSt1    = 4'd1,
    PhSt2    = 4'd2,
    PhSp1    = 4'd3,
    PhSp2    = 4'd4,
    PhWrLo   = 4'd5,
    PhWrNx   = 4'd6,
    PhWa1    = 4'd7,
    PhWaPoll = 4'd8,
    PhRdHi   = 4'd9,
    PhRdNx   = 4'd10,
    PhAk1    = 4'd11,
    PhAk2    = 4'd12
  } phase_e;

  // One tick of the bus timebase
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_t;

  // Pin and status snapshot after one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_input_mode;
    logic       busy_res;
    logic       done_res;
    logic       ack_failed;
    logic [7:0] rx_data;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/i2c_master_bit_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top: I2C master bit sequencer
// Runs START, STOP, byte write, ACK wait and byte read one bus tick per
// command-channel transaction and reports pin levels and status per tick.
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   in        input      in_valid_i/in_stall_o   i2cms_pkg::in_t
//   out       output     out_valid_o/out_stall_i i2cms_pkg::out_t
//   cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One tick transaction is taken per cycle while in_stall_o is low. The
// result of a tick is registered, in the skid register while a result waits.
// A two-entry output stage (result register plus skid register) keeps the
// input open for one more tick while a result waits; in_stall_o rises only
// when both entries are full. Reset puts the bus idle with SCL and SDA high.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  i2cms_pkg::in_t               in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output i2cms_pkg::out_t                    out_data_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [i2cms_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [i2cms_pkg::CfgDatW-1:0]      cfg_data_i
);

  // Configuration registers
  logic [7:0] half_period_q;
  logic [7:0] ack_timeout_q;

  // Sequencer state
  i2cms_pkg::phase_e phase_q, phase_d;
  logic [3:0] bit_index_q, bit_index_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] delay_q, delay_d;
  logic [7:0] poll_q, poll_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       sda_in_mode_q, sda_in_mode_d;
  logic       ack_choice_q, ack_choice_d;
  logic       ack_fail_q, ack_fail_d;
  logic [7:0] rx_q, rx_d;
  logic       done_d;

  // Output stage
  logic            out_valid_q;
  logic            skid_valid_q;
  i2cms_pkg::out_t out_q;
  i2cms_pkg::out_t skid_q;
  i2cms_pkg::out_t result_d;

  logic       in_fire;
  logic       out_fire;
  logic [3:0] bit_next;
  logic [8:0] poll_next;

  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign bit_next  = bit_index_q + 4'd1;
  assign poll_next = {1'b0, poll_q} + 9'd1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= i2cms_pkg::HalfPeriodReset;
      ack_timeout_q <= i2cms_pkg::AckTimeoutReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == i2cms_pkg::CfgHalfPeriod) begin
        half_period_q <= cfg_data_i;
      end else if (cfg_index_i == i2cms_pkg::CfgAckTimeout) begin
        ack_timeout_q <= cfg_data_i;
      end
    end
  end

  // Next state: accept a command when idle, else count down or run a segment
  always_comb begin
    phase_d       = phase_q;
    bit_index_d   = bit_index_q;
    shift_d       = shift_q;
    delay_d       = delay_q;
    poll_d        = poll_q;
    scl_d         = scl_q;
    sda_d         = sda_q;
    sda_in_mode_d = sda_in_mode_q;
    ack_choice_d  = ack_choice_q;
    ack_fail_d    = ack_fail_q;
    rx_d          = rx_q;
    done_d        = 1'b0;

    if (phase_q == i2cms_pkg::PhIdle) begin
      case (in_data_i.kind)
        i2cms_pkg::KindStart: begin
          sda_in_mode_d = 1'b0;
          sda_d         = 1'b1;
          scl_d         = 1'b1;
          delay_d       = half_period_q;
          phase_d       = i2cms_pkg::PhSt1;
        end
        i2cms_pkg::KindStop: begin
          sda_in_mode_d = 1'b0;
          scl_d         = 1'b0;
          sda_d         = 1'b0;
          delay_d       = half_period_q;
          phase_d       = i2cms_pkg::PhSp1;
        end
        i2cms_pkg::KindWrite: begin
          sda_in_mode_d = 1'b0;
          bit_index_d   = 4'd0;
          sda_d         = in_data_i.tx_byte[7];
          shift_d       = {in_data_i.tx_byte[6:0], 1'b0};
          scl_d         = 1'b1;
          delay_d       = half_period_q;
          phase_d       = i2cms_pkg::PhWrLo;
        end
        i2cms_pkg::KindAck: begin
          sda_in_mode_d = 1'b1;
          sda_d         = 1'b1;
          poll_d        = 8'd0;
          ack_fail_d    = 1'b0;
          delay_d       = half_period_q;
          phase_d       = i2cms_pkg::PhWa1;
        end
        i2cms_pkg::KindRead: begin
          sda_in_mode_d = 1'b1;
          bit_index_d   = 4'd0;
          shift_d       = 8'd0;
          ack_choice_d  = in_data_i.send_ack;
          scl_d         = 1'b0;
          delay_d       = half_period_q;
          phase_d       = i2cms_pkg::PhRdHi;
        end
        default: begin
        end
      endcase
    end else if (delay_q > 8'd1) begin
      delay_d = delay_q - 8'd1;
    end else begin
      delay_d = 8'd0;
      unique case (phase_q)
        i2cms_pkg::PhSt1: begin
          sda_d   = 1'b0;
          delay_d = half_period_q;
          phase_d = i2cms_pkg::PhSt2;
        end
        i2cms_pkg::PhSt2: begin
          scl_d   = 1'b0;
          phase_d = i2cms_pkg::PhIdle;
          done_d  = 1'b1;
        end
        i2cms_pkg::PhSp1: begin
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          delay_d = half_period_q;
          phase_d = i2cms_pkg::PhSp2;
        end
        i2cms_pkg::PhSp2: begin
          phase_d = i2cms_pkg::PhIdle;
          done_d  = 1'b1;
        end
        i2cms_pkg::PhWrLo: begin
          scl_d   = 1'b0;
          delay_d = half_period_q;
          phase_d = i2cms_pkg::PhWrNx;
        end
        i2cms_pkg::PhWrNx: begin
          bit_index_d = bit_next;
          if (bit_next >= i2cms_pkg::BitsPerByte) begin
            phase_d = i2cms_pkg::PhIdle;
            done_d  = 1'b1;
          end else begin
            sda_d   = shift_q[7];
            shift_d = {shift_q[6:0], 1'b0};
            scl_d   = 1'b1;
            delay_d = half_period_q;
            phase_d = i2cms_pkg::PhWrLo;
          end
        end
        i2cms_pkg::PhWa1: begin
          scl_d   = 1'b1;
          delay_d = half_period_q;
          phase_d = i2cms_pkg::PhWaPoll;
        end
        i2cms_pkg::PhWaPoll: begin
          if (!in_data_i.sda_in) begin
            scl_d   = 1'b0;
            phase_d = i2cms_pkg::PhIdle;
            done_d  = 1'b1;
          end else if (poll_next > {1'b0, ack_timeout_q}) begin
            // Give up: flag and start a STOP on this tick
            ack_fail_d    = 1'b1;
            sda_in_mode_d = 1'b0;
            scl_d         = 1'b0;
            sda_d         = 1'b0;
            delay_d       = half_period_q;
            phase_d       = i2cms_pkg::PhSp1;
          end else begin
            poll_d = poll_next[7:0];
          end
        end
        i2cms_pkg::PhRdHi: begin
          scl_d   = 1'b1;
          shift_d = {shift_q[6:0], in_data_i.sda_in};
          delay_d = half_period_q;
          phase_d = i2cms_pkg::PhRdNx;
        end
        i2cms_pkg::PhRdNx: begin
          bit_index_d = bit_next;
          scl_d       = 1'b0;
          delay_d     = half_period_q;
          if (bit_next < i2cms_pkg::BitsPerByte) begin
            phase_d = i2cms_pkg::PhRdHi;
          end else begin
            // Drive the ACK or NACK bit
            sda_in_mode_d = 1'b0;
            sda_d         = !ack_choice_q;
            phase_d       = i2cms_pkg::PhAk1;
          end
        end
        i2cms_pkg::PhAk1: begin
          scl_d   = 1'b1;
          delay_d = half_period_q;
          phase_d = i2cms_pkg::PhAk2;
        end
        i2cms_pkg::PhAk2: begin
          scl_d   = 1'b0;
          rx_d    = shift_q;
          phase_d = i2cms_pkg::PhIdle;
          done_d  = 1'b1;
        end
        default: begin
          phase_d = i2cms_pkg::PhIdle;
        end
      endcase
    end
  end

  // Outputs: pack the state after this tick into a result
  always_comb begin
    result_d.scl_level      = scl_d;
    result_d.sda_level      = sda_d;
    result_d.sda_input_mode = sda_in_mode_d;
    result_d.busy_res       = (phase_d != i2cms_pkg::PhIdle);
    result_d.done_res       = done_d;
    result_d.ack_failed     = ack_fail_d;
    result_d.rx_data        = rx_d;
  end

  // Advance the sequencer state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= i2cms_pkg::PhIdle;
      bit_index_q   <= 4'd0;
      shift_q       <= 8'd0;
      delay_q       <= 8'd0;
      poll_q        <= 8'd0;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      sda_in_mode_q <= 1'b0;
      ack_choice_q  <= 1'b0;
      ack_fail_q    <= 1'b0;
      rx_q          <= 8'd0;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      bit_index_q   <= bit_index_d;
      shift_q       <= shift_d;
      delay_q       <= delay_d;
      poll_q        <= poll_d;
      scl_q         <= scl_d;
      sda_q         <= sda_d;
      sda_in_mode_q <= sda_in_mode_d;
      ack_choice_q  <= ack_choice_d;
      ack_fail_q    <= ack_fail_d;
      rx_q          <= rx_d;
    end
  end

  // Output stage control: result register with a skid register behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= result_d;
      end else begin
        out_q <= result_d;
      end
    end
  end

endmodule

`default_nettype wire
